@@ hw/rtl/rtcwa_pkg.sv @@
// ============================================================================
// rtcwa_pkg: shared types and constants for the RTC wake-up alarm calculator
// Transfer payload structs, calendar constants, reciprocal divide constants
// and small calendar lookup functions.
// ============================================================================
package rtcwa_pkg;

    // operation codes
    localparam logic FUNC_SET_ALARM = 1'b0;
    localparam logic FUNC_ELAPSED   = 1'b1;

    // subsecond compare masks
    localparam logic [3:0] SSMASK_PERIODIC = 4'd3;
    localparam logic [3:0] SSMASK_FULL     = 4'd15;

    // width of the subsecond fields on the ports
    localparam int unsigned SUB_FIELD_W = 10;

    // calendar constants
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN    = 6'd60;
    localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
    localparam logic [8:0]  DAYS_NORM_YEAR  = 9'd365;
    localparam logic [8:0]  DAYS_LEAP_YEAR  = 9'd366;
    localparam logic [10:0] DAYS_PER_4YR    = 11'(3 * DAYS_NORM_YEAR + DAYS_LEAP_YEAR);
    localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [3:0]  FEB_INDEX       = 4'd1;
    localparam logic [4:0]  FEB_LEAP_DAYS   = 5'd29;
    localparam logic [9:0]  MONTH_PAIR_DAYS = 10'd61;

    // packed two-bit month corrections, normal and leap years
    localparam logic [23:0] CORR_NORM = 24'h99AAA0;
    localparam logic [23:0] CORR_LEAP = 24'h445550;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // timeout seconds fit in 28 bits for the smallest subsecond width
    localparam int unsigned TSEC_W = 28;

    // x / 86400 = ((x >> 7) * DAY_RECIP) >> 31, exact for x >> 7 below 2^21
    localparam int unsigned  DAY_PRESHIFT    = 7;
    localparam logic [21:0]  DAY_RECIP       = 22'd3181458;
    localparam int unsigned  DAY_RECIP_SHIFT = 31;

    // x / 60 = ((x >> 2) * DIV15_RECIP) >> 19, exact for x >> 2 below 2^15
    localparam logic [15:0]  DIV15_RECIP = 16'd34953;
    localparam int unsigned  DIV15_SHIFT = 19;

    // x / month length = (x * dim_recip) >> 17, exact for x below 2^12
    localparam int unsigned  DIM_RECIP_SHIFT = 17;

    typedef struct packed {
        logic        func;
        logic [6:0]  cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_date;
        logic [4:0]  cal_hours;
        logic [5:0]  cal_minutes;
        logic [5:0]  cal_seconds;
        logic [9:0]  cal_subsecond;
        logic [31:0] timeout_ticks;
        logic        periodic;
    } in_t;

    typedef struct packed {
        logic [5:0]  alarm_seconds;
        logic [5:0]  alarm_minutes;
        logic [4:0]  alarm_hours;
        logic [4:0]  alarm_day;
        logic [9:0]  alarm_subsecond;
        logic        mask_calendar;
        logic [3:0]  subsecond_mask;
        logic [31:0] reference_ticks_out;
        logic [31:0] elapsed_ticks;
    } out_t;

    // carry count and remainder of a small value against a modulus
    typedef struct packed {
        logic [1:0] carry;
        logic [6:0] rem;
    } wrap_t;

    // month 0 counts as January, anything past December as December
    function automatic logic [3:0] month_index(input logic [3:0] month);
        logic [3:0] idx;
        if (month == 4'd0)
        begin
            idx = 4'd0;
        end
        else if (month > MONTHS_PER_YEAR)
        begin
            idx = MONTHS_PER_YEAR - 4'd1;
        end
        else
        begin
            idx = month - 4'd1;
        end
        return idx;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mi, input logic leap);
        logic [4:0] d;
        d = MONTH_LEN[mi];
        if (leap && mi == FEB_INDEX)
        begin
            d = FEB_LEAP_DAYS;
        end
        return d;
    endfunction

    // days from Jan 1 to the first of month mi
    function automatic logic [8:0] month_offset(input logic [3:0] mi, input logic leap);
        logic [23:0] corr;
        logic [9:0]  half;
        logic [1:0]  adj;
        corr = leap ? CORR_LEAP : CORR_NORM;
        half = (10'(mi) * MONTH_PAIR_DAYS + 10'd1) >> 1;
        adj  = corr[{mi, 1'b0} +: 2];
        return 9'(half - 10'(adj));
    endfunction

    // reciprocal for the month length (28..31)
    function automatic logic [12:0] dim_recip(input logic [4:0] dim);
        logic [12:0] r;
        case (dim)
            5'd28:   r = 13'd4682;
            5'd29:   r = 13'd4520;
            5'd30:   r = 13'd4370;
            default: r = 13'd4229;
        endcase
        return r;
    endfunction

    // value below three times the modulus
    function automatic wrap_t wrap_mod(input logic [6:0] value, input logic [6:0] modulus);
        wrap_t      w;
        logic [7:0] twice;
        twice = {modulus, 1'b0};
        if ({1'b0, value} >= twice)
        begin
            w.carry = 2'd2;
            w.rem   = 7'({1'b0, value} - twice);
        end
        else if (value >= modulus)
        begin
            w.carry = 2'd1;
            w.rem   = value - modulus;
        end
        else
        begin
            w.carry = 2'd0;
            w.rem   = value;
        end
        return w;
    endfunction

endpackage

@@ hw/rtl/rtc_wakeup_alarm_calculator.sv @@
// ============================================================================
// rtc_wakeup_alarm_calculator
// Converts an RTC calendar to a tick stamp, keeps the alarm reference and
// computes the alarm calendar fields for a tick timeout.
// ============================================================================
// Fully pipelined: one item is taken per clock while the output is not stalled,
// and its result is presented after 8 register stages (including the input
// and output registers). The depth comes from the chain of reciprocal
// multiplies that split the timeout into days, hours, minutes and seconds,
// the days-times-86400 stamp multiply, and the final month-length modulo.
// Each stage holds its item while the next is full, so bubbles collapse and
// the input keeps flowing while a result waits at the output. A set-alarm
// item updates the stored reference when it passes stage 4; an elapsed item
// sees every earlier set-alarm in transfer order. SUBSEC_BITS may be 4..15;
// the subsecond fields on the ports stay 10 bits wide.
module rtc_wakeup_alarm_calculator #(
    parameter int unsigned SUBSEC_BITS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rtcwa_pkg::in_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rtcwa_pkg::out_t  out_data
);
    import rtcwa_pkg::*;

    localparam int unsigned NSTG = 8;
    localparam logic [SUBSEC_BITS-1:0] PREDIV = {SUBSEC_BITS{1'b1}};

    // fields carried down the pipe
    typedef struct packed {
        logic        func;
        logic        periodic;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [4:0]  date;
        logic [4:0]  dim;
        logic [9:0]  asub;
        logic        sub_carry;
    } ctl_t;

    typedef struct packed {
        ctl_t                   ctl;
        logic [15:0]            dp;
        logic [16:0]            tod;
        logic [TSEC_W-1:0]      tsec;
        logic [11:0]            q_day;
        logic [SUBSEC_BITS-1:0] esub;
    } s1_t;

    typedef struct packed {
        ctl_t                   ctl;
        logic [31:0]            stamp_prod;
        logic [16:0]            tod;
        logic [SUBSEC_BITS-1:0] esub;
        logic [16:0]            rem_day;
        logic [11:0]            q_day;
    } s2_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] stamp;
        logic [16:0] rem_day;
        logic [10:0] q60;
        logic [11:0] q_day;
    } s3_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] ref_out;
        logic [31:0] elapsed;
        logic [10:0] q60;
        logic [5:0]  s_rem;
        logic [4:0]  q_h;
        logic [11:0] q_day;
    } s4_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] ref_out;
        logic [31:0] elapsed;
        logic [5:0]  secs;
        logic [5:0]  mins;
        logic [4:0]  hours;
        logic [11:0] days;
    } s5_t;

    typedef struct packed {
        s5_t         t;
        logic [7:0]  q_dim;
    } s6_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] en;
    logic [31:0]     ref_reg;
    logic [31:0]     ref_next;

    in_t  in_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    s5_t  s5_reg, s5_next;
    s6_t  s6_reg, s6_next;
    out_t out_reg, out_next;

    // stage flow control: a stage loads when empty or when it drains
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    // reference captured as a set-alarm item moves into stage 4
    always_comb
    begin
        ref_next = ref_reg;
        if (vld_reg[3] && en[4] && s3_reg.ctl.func == FUNC_SET_ALARM)
        begin
            ref_next = s3_reg.stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ref_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            ref_reg <= ref_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en[0]) in_reg  <= in_data;
        if (en[1]) s1_reg  <= s1_next;
        if (en[2]) s2_reg  <= s2_next;
        if (en[3]) s3_reg  <= s3_next;
        if (en[4]) s4_reg  <= s4_next;
        if (en[5]) s5_reg  <= s5_next;
        if (en[6]) s6_reg  <= s6_next;
        if (en[7]) out_reg <= out_next;
    end

    // stage 1: day number, time of day, subsecond sum, timeout day quotient
    logic [3:0]             mi;
    logic                   leap;
    logic [17:0]            yr4;
    logic [31:0]            tsec_full;
    logic [42:0]            qday_prod;
    logic [31:0]            sub_ext;
    logic [SUBSEC_BITS-1:0] sub_w;
    logic [SUBSEC_BITS-1:0] esub;
    logic [SUBSEC_BITS:0]   subsum;
    logic [SUBSEC_BITS-1:0] asub;
    logic [31:0]            asub_ext;

    assign mi        = month_index(in_reg.cal_month);
    assign leap      = (in_reg.cal_year[1:0] == 2'd0);
    assign yr4       = 18'(in_reg.cal_year) * 18'(DAYS_PER_4YR) + 18'd3;
    assign tsec_full = in_reg.timeout_ticks >> SUBSEC_BITS;
    assign qday_prod = 43'(tsec_full[TSEC_W-1:DAY_PRESHIFT]) * 43'(DAY_RECIP);
    assign sub_ext   = 32'(in_reg.cal_subsecond);
    assign sub_w     = sub_ext[SUBSEC_BITS-1:0];
    assign esub      = PREDIV - sub_w;
    assign subsum    = {1'b0, esub} + {1'b0, in_reg.timeout_ticks[SUBSEC_BITS-1:0]};
    assign asub      = PREDIV - subsum[SUBSEC_BITS-1:0];
    assign asub_ext  = 32'(asub);

    always_comb
    begin
        s1_next.ctl.func      = in_reg.func;
        s1_next.ctl.periodic  = in_reg.periodic;
        s1_next.ctl.seconds   = in_reg.cal_seconds;
        s1_next.ctl.minutes   = in_reg.cal_minutes;
        s1_next.ctl.hours     = in_reg.cal_hours;
        s1_next.ctl.date      = in_reg.cal_date;
        s1_next.ctl.dim       = month_days(mi, leap);
        s1_next.ctl.asub      = asub_ext[SUB_FIELD_W-1:0];
        s1_next.ctl.sub_carry = subsum[SUBSEC_BITS];
        s1_next.dp            = yr4[17:2] + 16'(month_offset(mi, leap))
                              + 16'(in_reg.cal_date);
        s1_next.tod           = 17'(in_reg.cal_hours) * 17'(SECS_PER_HOUR)
                              + 17'(in_reg.cal_minutes) * 17'(SECS_PER_MIN)
                              + 17'(in_reg.cal_seconds);
        s1_next.tsec          = tsec_full[TSEC_W-1:0];
        s1_next.q_day         = 12'(qday_prod >> DAY_RECIP_SHIFT);
        s1_next.esub          = esub;
    end

    // stage 2: seconds of the day number, timeout remainder within a day
    logic [32:0] stamp_prod_w;
    logic [28:0] qd_secs;
    logic [28:0] rem_w;

    assign stamp_prod_w = 33'(s1_reg.dp) * 33'(SECS_PER_DAY);
    assign qd_secs      = 29'(s1_reg.q_day) * 29'(SECS_PER_DAY);
    assign rem_w        = 29'(s1_reg.tsec) - qd_secs;

    always_comb
    begin
        s2_next.ctl        = s1_reg.ctl;
        s2_next.stamp_prod = stamp_prod_w[31:0];
        s2_next.tod        = s1_reg.tod;
        s2_next.esub       = s1_reg.esub;
        s2_next.rem_day    = rem_w[16:0];
        s2_next.q_day      = s1_reg.q_day;
    end

    // stage 3: tick stamp, remainder split into whole minutes
    logic [31:0] secs32;
    logic [30:0] q60_prod;

    assign secs32   = s2_reg.stamp_prod - 32'(SECS_PER_DAY) + 32'(s2_reg.tod);
    assign q60_prod = 31'(s2_reg.rem_day[16:2]) * 31'(DIV15_RECIP);

    always_comb
    begin
        s3_next.ctl     = s2_reg.ctl;
        s3_next.stamp   = {secs32[31-SUBSEC_BITS:0], s2_reg.esub};
        s3_next.rem_day = s2_reg.rem_day;
        s3_next.q60     = 11'(q60_prod >> DIV15_SHIFT);
        s3_next.q_day   = s2_reg.q_day;
    end

    // stage 4: elapsed ticks, second remainder, hour quotient
    logic [16:0] q60_secs;
    logic [16:0] srem_w;
    logic [24:0] qh_prod;

    assign q60_secs = 17'(s3_reg.q60) * 17'(SECS_PER_MIN);
    assign srem_w   = s3_reg.rem_day - q60_secs;
    assign qh_prod  = 25'(s3_reg.q60[10:2]) * 25'(DIV15_RECIP);

    always_comb
    begin
        s4_next.ctl   = s3_reg.ctl;
        s4_next.q60   = s3_reg.q60;
        s4_next.s_rem = srem_w[5:0];
        s4_next.q_h   = 5'(qh_prod >> DIV15_SHIFT);
        s4_next.q_day = s3_reg.q_day;
        if (s3_reg.ctl.func == FUNC_ELAPSED)
        begin
            s4_next.ref_out = ref_reg;
            s4_next.elapsed = s3_reg.stamp - ref_reg;
        end
        else
        begin
            s4_next.ref_out = s3_reg.stamp;
            s4_next.elapsed = '0;
        end
    end

    // stage 5: add to the calendar and ripple the carries
    logic [10:0] qh60;
    logic [10:0] mrem_w;
    wrap_t       sec_w;
    wrap_t       min_w;
    wrap_t       hour_w;

    assign qh60   = 11'(s4_reg.q_h) * 11'(SECS_PER_MIN);
    assign mrem_w = s4_reg.q60 - qh60;
    assign sec_w  = wrap_mod(7'(s4_reg.ctl.seconds) + 7'(s4_reg.s_rem)
                             + 7'(s4_reg.ctl.sub_carry), 7'(SECS_PER_MIN));
    assign min_w  = wrap_mod(7'(s4_reg.ctl.minutes) + 7'(mrem_w[5:0])
                             + 7'(sec_w.carry), 7'(SECS_PER_MIN));
    assign hour_w = wrap_mod(7'(s4_reg.ctl.hours) + 7'(s4_reg.q_h)
                             + 7'(min_w.carry), 7'(HOURS_PER_DAY));

    always_comb
    begin
        s5_next.ctl     = s4_reg.ctl;
        s5_next.ref_out = s4_reg.ref_out;
        s5_next.elapsed = s4_reg.elapsed;
        s5_next.secs    = sec_w.rem[5:0];
        s5_next.mins    = min_w.rem[5:0];
        s5_next.hours   = hour_w.rem[4:0];
        s5_next.days    = 12'(s4_reg.ctl.date) + s4_reg.q_day + 12'(hour_w.carry);
    end

    // stage 6: quotient of the day count by the month length
    logic [24:0] qdim_prod;

    assign qdim_prod = 25'(s5_reg.days) * 25'(dim_recip(s5_reg.ctl.dim));

    always_comb
    begin
        s6_next.t     = s5_reg;
        s6_next.q_dim = 8'(qdim_prod >> DIM_RECIP_SHIFT);
    end

    // stage 7: single month wrap and result assembly
    logic [12:0] qdim_days;
    logic [11:0] dfix;
    logic [4:0]  day_out;

    assign qdim_days = 13'(s6_reg.q_dim) * 13'(s6_reg.t.ctl.dim);
    assign dfix      = s6_reg.t.days - qdim_days[11:0];
    assign day_out   = (s6_reg.t.days > 12'(s6_reg.t.ctl.dim)) ? dfix[4:0]
                                                               : s6_reg.t.days[4:0];

    always_comb
    begin
        out_next                     = '0;
        out_next.reference_ticks_out = s6_reg.t.ref_out;
        out_next.elapsed_ticks       = s6_reg.t.elapsed;
        if (s6_reg.t.ctl.func == FUNC_SET_ALARM)
        begin
            out_next.alarm_seconds   = s6_reg.t.secs;
            out_next.alarm_minutes   = s6_reg.t.mins;
            out_next.alarm_hours     = s6_reg.t.hours;
            out_next.alarm_day       = day_out;
            out_next.alarm_subsecond = s6_reg.t.ctl.asub;
            out_next.mask_calendar   = s6_reg.t.ctl.periodic;
            out_next.subsecond_mask  = s6_reg.t.ctl.periodic ? SSMASK_PERIODIC
                                                             : SSMASK_FULL;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = out_reg;

endmodule

@@ hw/rtl/rtcwa_checker.sv @@
// ============================================================================
// rtcwa_checker: port-level checks for the RTC wake-up alarm calculator
// Watches the result channel for hold behavior, reset state and the value
// ranges and field combinations that the datapath must produce.
// ============================================================================
module rtcwa_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input rtcwa_pkg::out_t out_data
);
    import rtcwa_pkg::*;

    // stalled result transfer keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // carry normalization keeps time fields in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.alarm_seconds < SECS_PER_MIN
                   && out_data.alarm_minutes < SECS_PER_MIN
                   && out_data.alarm_hours < HOURS_PER_DAY)
        else $error("alarm time field out of range");

    // a nonzero elapsed count only comes from an elapsed item
    a_elapsed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.elapsed_ticks != 32'd0 |->
            out_data.alarm_seconds == '0 && out_data.alarm_minutes == '0
            && out_data.alarm_hours == '0 && out_data.alarm_day == '0
            && out_data.alarm_subsecond == '0 && !out_data.mask_calendar
            && out_data.subsecond_mask == '0)
        else $error("alarm fields set on an elapsed result");

    // periodic alarms use the short subsecond mask
    a_periodic_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mask_calendar |-> out_data.subsecond_mask == SSMASK_PERIODIC)
        else $error("periodic alarm with wrong subsecond mask");

endmodule

bind rtc_wakeup_alarm_calculator rtcwa_checker u_rtcwa_checker (.*);

@@ tb/tb_rtc_wakeup_alarm_calculator.sv @@
// ============================================================================
// tb_rtc_wakeup_alarm_calculator: self-checking bench for the alarm calculator
// Drives calendar items through the valid/ready input, predicts every result
// (tick stamp, alarm fields, elapsed ticks) with its own calendar arithmetic
// and checks each output transfer field by field, under random idling on both
// sides and one long output hold-off that backs the pipeline up.
// ============================================================================
module tb_rtc_wakeup_alarm_calculator;
    timeunit 1ns;
    timeprecision 1ps;

    import rtcwa_pkg::*;

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned SUB_BITS    = 10;
    localparam logic [31:0] FULL_SCALE  = 32'((1 << SUB_BITS) - 1);
    localparam logic [31:0] DAY_SECS    = 32'd86400;
    localparam logic [31:0] HOUR_SECS   = 32'd3600;
    localparam logic [31:0] MIN_SECS    = 32'd60;
    localparam logic [31:0] QUAD_DAYS   = 32'd1461;
    localparam logic [31:0] NORM_CORR   = 32'h0099AAA0;
    localparam logic [31:0] LEAP_CORR   = 32'h00445550;
    localparam int unsigned RAND_ITEMS  = 1000;
    localparam int unsigned HOLD_AT     = 800;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                               31, 31, 30, 31, 30, 31};

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_ready;
    in_t    in_data   = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    out_t   out_data;

    in_t            pending_items [$];
    out_t           pending_results [$];
    logic [31:0]    alarm_reference = '0;
    int unsigned    send_idle_pct   = 0;
    int unsigned    recv_idle_pct   = 0;
    int unsigned    errors          = 0;
    int unsigned    results_seen    = 0;
    int unsigned    hold_left       = 0;
    bit             hold_done       = 1'b0;
    int unsigned    cycle_count     = 0;

    rtc_wakeup_alarm_calculator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Calendar arithmetic: stamp, alarm fields, elapsed ticks; updates the
    // stored reference on set-alarm
    // ------------------------------------------------------------------------
    function automatic out_t predict_alarm(input in_t item);
        out_t        res;
        logic [31:0] yr, mi, sub, corr, days, secs, stamp;
        logic [31:0] tmo, subsum, tsec, rem, s, m, h, d, dim;
        res = '0;
        yr  = 32'(item.cal_year);
        // month 0 counts as January, past December as December
        if (item.cal_month == 4'd0)
            mi = 32'd0;
        else if (item.cal_month > 4'd12)
            mi = 32'd11;
        else
            mi = 32'(item.cal_month) - 32'd1;
        sub  = 32'(item.cal_subsecond) & FULL_SCALE;
        corr = (yr[1:0] == 2'd0) ? LEAP_CORR : NORM_CORR;

        // tick stamp, all modulo 2^32
        days  = (QUAD_DAYS * yr + 32'd3) / 32'd4;
        days  = days + (mi * 32'd61 + 32'd1) / 32'd2 - ((corr >> (mi * 32'd2)) & 32'd3);
        days  = days + 32'(item.cal_date) - 32'd1;
        secs  = days * DAY_SECS + 32'(item.cal_seconds) + 32'(item.cal_minutes) * MIN_SECS
              + 32'(item.cal_hours) * HOUR_SECS;
        stamp = (secs << SUB_BITS) + (FULL_SCALE - sub);

        if (item.func == FUNC_ELAPSED)
        begin
            res.reference_ticks_out = alarm_reference;
            res.elapsed_ticks       = stamp - alarm_reference;
        end
        else
        begin
            alarm_reference = stamp;
            tmo    = item.timeout_ticks;
            subsum = (FULL_SCALE - sub) + (tmo & FULL_SCALE);
            tsec   = tmo >> SUB_BITS;

            // split the timeout and add it field by field
            d   = 32'(item.cal_date) + tsec / DAY_SECS;
            rem = tsec % DAY_SECS;
            h   = 32'(item.cal_hours) + rem / HOUR_SECS;
            rem = rem % HOUR_SECS;
            m   = 32'(item.cal_minutes) + rem / MIN_SECS;
            s   = 32'(item.cal_seconds) + rem % MIN_SECS;
            if (subsum > FULL_SCALE)
            begin
                subsum = subsum - (FULL_SCALE + 32'd1);
                s      = s + 32'd1;
            end
            m = m + s / 60;
            s = s % 60;
            h = h + m / 60;
            m = m % 60;
            d = d + h / 24;
            h = h % 24;

            // single month wrap, may leave a day of 0
            dim = 32'(MONTH_DAYS[mi]);
            if (mi == 32'd1 && yr[1:0] == 2'd0)
                dim = 32'd29;
            if (d > dim)
                d = d % dim;

            res.alarm_seconds       = s[5:0];
            res.alarm_minutes       = m[5:0];
            res.alarm_hours         = h[4:0];
            res.alarm_day           = d[4:0];
            res.alarm_subsecond     = 10'(FULL_SCALE - subsum);
            res.mask_calendar       = item.periodic;
            res.subsecond_mask      = item.periodic ? SSMASK_PERIODIC : SSMASK_FULL;
            res.reference_ticks_out = stamp;
        end
        return res;
    endfunction

    function automatic in_t make_item(input logic fn, input int unsigned yr, input int unsigned mo,
                                      input int unsigned dt, input int unsigned hr,
                                      input int unsigned mn, input int unsigned sc,
                                      input int unsigned ss, input logic [31:0] tmo,
                                      input logic per);
        in_t item;
        item.func          = fn;
        item.cal_year      = 7'(yr);
        item.cal_month     = 4'(mo);
        item.cal_date      = 5'(dt);
        item.cal_hours     = 5'(hr);
        item.cal_minutes   = 6'(mn);
        item.cal_seconds   = 6'(sc);
        item.cal_subsecond = 10'(ss);
        item.timeout_ticks = tmo;
        item.periodic      = per;
        return item;
    endfunction

    // mostly sane calendars with varied timeouts, some raw noise
    function automatic in_t random_item();
        in_t         item;
        int unsigned mo, len, yr;
        logic [31:0] tmo;
        logic [95:0] raw;
        if ($urandom_range(99) < 10)
        begin
            raw  = {$urandom, $urandom, $urandom};
            item = raw[$bits(in_t)-1:0];
        end
        else
        begin
            yr  = $urandom_range(99);
            mo  = $urandom_range(1, 12);
            len = MONTH_DAYS[mo - 1];
            if (mo == 2 && yr % 4 == 0)
                len = 29;
            case ($urandom_range(3))
                0:       tmo = $urandom_range(1023);
                1:       tmo = $urandom_range(65535);
                2:       tmo = $urandom_range(32'd265420800);
                default: tmo = $urandom;
            endcase
            item = make_item($urandom_range(1) ? FUNC_ELAPSED : FUNC_SET_ALARM, yr, mo,
                             $urandom_range(1, len), $urandom_range(23), $urandom_range(59),
                             $urandom_range(59), $urandom_range(1023), tmo,
                             1'($urandom_range(1)));
        end
        return item;
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d (0x%08h), got %0d (0x%08h)",
                     $time, name, want, want, got, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: predicts on each accepted transfer, then offers the next
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_input
        logic fire;
        fire = in_valid && in_ready;
        if (rst_n)
        begin
            if (fire)
                pending_results.push_back(predict_alarm(in_data));
            if (!in_valid || fire)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: checks each transfer, drives ready with random stalls
    // and one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_output
        out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected, got %p", $time, out_data);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("alarm_seconds", 32'(out_data.alarm_seconds),
                                32'(want.alarm_seconds));
                    check_field("alarm_minutes", 32'(out_data.alarm_minutes),
                                32'(want.alarm_minutes));
                    check_field("alarm_hours", 32'(out_data.alarm_hours),
                                32'(want.alarm_hours));
                    check_field("alarm_day", 32'(out_data.alarm_day), 32'(want.alarm_day));
                    check_field("alarm_subsecond", 32'(out_data.alarm_subsecond),
                                32'(want.alarm_subsecond));
                    check_field("mask_calendar", 32'(out_data.mask_calendar),
                                32'(want.mask_calendar));
                    check_field("subsecond_mask", 32'(out_data.subsecond_mask),
                                32'(want.subsecond_mask));
                    check_field("reference_ticks_out", out_data.reference_ticks_out,
                                want.reference_ticks_out);
                    check_field("elapsed_ticks", out_data.elapsed_ticks, want.elapsed_ticks);
                end
                results_seen++;
            end

            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("rtc_wakeup_alarm_calculator: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed corners, then three random phases
    // ------------------------------------------------------------------------
    initial
    begin : run_test
        int unsigned phase;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 51;

        // elapsed against the reset reference, smallest calendar
        pending_items.push_back(make_item(FUNC_ELAPSED, 0, 1, 1, 0, 0, 0, 1023, 0, 1'b0));
        // set at the epoch with no timeout, then elapsed at the same time
        pending_items.push_back(make_item(FUNC_SET_ALARM, 0, 1, 1, 0, 0, 0, 1023, 0, 1'b0));
        pending_items.push_back(make_item(FUNC_ELAPSED, 0, 1, 1, 0, 0, 0, 1023, 0, 1'b1));
        // largest sane calendar with the largest timeout, periodic
        pending_items.push_back(make_item(FUNC_SET_ALARM, 99, 12, 31, 23, 59, 59, 0,
                                          32'hFFFF_FFFF, 1'b1));
        // elapsed going backwards wraps around 2^32
        pending_items.push_back(make_item(FUNC_ELAPSED, 0, 1, 1, 0, 0, 0, 0, 0, 1'b0));
        // one tick at year end ripples every carry up to the day wrap
        pending_items.push_back(make_item(FUNC_SET_ALARM, 98, 12, 31, 23, 59, 59, 0, 1, 1'b0));
        // leap February: one day later is the 29th, no wrap
        pending_items.push_back(make_item(FUNC_SET_ALARM, 4, 2, 28, 10, 0, 0, 512,
                                          32'(DAY_SECS) << SUB_BITS, 1'b0));
        // normal February: one day later wraps to the 1st
        pending_items.push_back(make_item(FUNC_SET_ALARM, 3, 2, 28, 10, 0, 0, 512,
                                          32'(DAY_SECS) << SUB_BITS, 1'b1));
        // 28 days after Feb 28 lands exactly on a multiple: alarm day 0
        pending_items.push_back(make_item(FUNC_SET_ALARM, 1, 2, 28, 0, 0, 0, 1023,
                                          (32'd28 * DAY_SECS) << SUB_BITS, 1'b0));
        // subsecond carry only, and subsecond without carry
        pending_items.push_back(make_item(FUNC_SET_ALARM, 20, 6, 15, 12, 30, 30, 0,
                                          32'd1023, 1'b0));
        pending_items.push_back(make_item(FUNC_SET_ALARM, 20, 6, 15, 12, 30, 30, 1023,
                                          32'd1023, 1'b1));
        // month zero and months past December
        pending_items.push_back(make_item(FUNC_SET_ALARM, 8, 0, 20, 5, 5, 5, 100,
                                          32'h0123_4567, 1'b0));
        pending_items.push_back(make_item(FUNC_ELAPSED, 8, 13, 20, 5, 5, 5, 100, 0, 1'b0));
        pending_items.push_back(make_item(FUNC_SET_ALARM, 9, 15, 31, 5, 5, 5, 100,
                                          32'h00FF_FFFF, 1'b1));
        // date zero, one day before the first of the month
        pending_items.push_back(make_item(FUNC_SET_ALARM, 12, 3, 0, 0, 0, 0, 700,
                                          32'h0001_0000, 1'b0));
        pending_items.push_back(make_item(FUNC_ELAPSED, 12, 3, 0, 0, 0, 1, 700, 0, 1'b0));
        // every time field past its range, largest year
        pending_items.push_back(make_item(FUNC_SET_ALARM, 127, 12, 31, 31, 63, 63, 0,
                                          32'hFFFF_FFFF, 1'b0));
        pending_items.push_back(make_item(FUNC_ELAPSED, 127, 15, 31, 31, 63, 63, 1023,
                                          32'hFFFF_FFFF, 1'b1));
        // all-ones payload and a stamp that overflows 32 bits
        pending_items.push_back(in_t'('1));
        pending_items.push_back(make_item(FUNC_SET_ALARM, 99, 12, 31, 23, 59, 59, 1023,
                                          32'h8000_0000, 1'b0));
        pending_items.push_back(make_item(FUNC_ELAPSED, 50, 7, 4, 12, 0, 0, 300, 0, 1'b0));

        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 17;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (RAND_ITEMS / 3 + 1)
                pending_items.push_back(random_item());
            while (pending_items.size() != 0 || in_valid)
                @(negedge clk);
        end

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (errors == 0)
            $display("rtc_wakeup_alarm_calculator: match");
        else
            $display("rtc_wakeup_alarm_calculator: mismatch");
        $finish;
    end

endmodule
